[sv/ccp_pkg.sv]
// Shared types and constant tables of the CSS colour string parser.
// No dependencies; every other file of the block but ccp_if refers to this package.
`default_nettype none

package ccp_pkg;

  localparam int unsigned NAME_COUNT      = 27;
  localparam int unsigned IDX_TRANSPARENT = 26;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_G  = 8'h67;
  localparam logic [7:0] CH_LOW_B  = 8'h62;

  // One character after classification by the front end.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] lc;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_digit;
  } ccp_char_t;

  // One queue entry.
  typedef struct packed {
    ccp_char_t c;
    logic      last;
  } ccp_item_t;

  // Names right-justified in 88 bits: byte p of a name of length L sits at [(L-1-p)*8 +: 8].
  localparam logic [87:0] NAME_STR [NAME_COUNT] = '{
    "black", "white", "red", "green", "blue", "navy", "gray", "grey",
    "silver", "orange", "purple", "teal", "maroon", "olive", "yellow", "lime",
    "aqua", "fuchsia", "pink", "brown", "gold", "darkgray", "darkgrey",
    "lightgray", "lightgrey", "whitesmoke", "transparent"
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd6, 4'd4, 4'd6, 4'd5, 4'd6, 4'd4,
    4'd4, 4'd7, 4'd4, 4'd5, 4'd4, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd10, 4'd11
  };

  // Red, green, blue packed as {r, g, b}.
  localparam logic [23:0] NAME_RGB [NAME_COUNT] = '{
    {8'd0, 8'd0, 8'd0},       {8'd255, 8'd255, 8'd255}, {8'd200, 8'd32, 8'd32},
    {8'd24, 8'd150, 8'd60},   {8'd40, 8'd90, 8'd210},   {8'd16, 8'd32, 8'd90},
    {8'd128, 8'd128, 8'd128}, {8'd128, 8'd128, 8'd128}, {8'd192, 8'd192, 8'd192},
    {8'd230, 8'd130, 8'd30},  {8'd130, 8'd50, 8'd160},  {8'd20, 8'd130, 8'd130},
    {8'd140, 8'd30, 8'd30},   {8'd120, 8'd120, 8'd20},  {8'd210, 8'd190, 8'd20},
    {8'd60, 8'd190, 8'd60},   {8'd40, 8'd190, 8'd200},  {8'd210, 8'd50, 8'd180},
    {8'd235, 8'd140, 8'd170}, {8'd140, 8'd80, 8'd40},   {8'd210, 8'd170, 8'd30},
    {8'd100, 8'd100, 8'd100}, {8'd100, 8'd100, 8'd100}, {8'd215, 8'd215, 8'd215},
    {8'd215, 8'd215, 8'd215}, {8'd245, 8'd245, 8'd245}, {8'd0, 8'd0, 8'd0}
  };

endpackage

`default_nettype wire

[sv/ccp_if.sv]
// Valid/ready channel interfaces of the CSS colour string parser.
// No dependencies.
`default_nettype none

interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ccp_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output valid_res, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input valid_res, input red, input green, input blue,
                  output ready);
endinterface

`default_nettype wire

[sv/ccp_front.sv]
// Front end: accepts characters and classifies them (case, hex, decimal).
// Depends on ccp_pkg and ccp_in_if.
`default_nettype none

module ccp_front (
  ccp_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              push,
  output ccp_pkg::ccp_item_t item
);

  logic [7:0] ch;
  logic       up;

  assign ch = in_chan.ch;
  assign up = (ch >= 8'h41) && (ch <= 8'h5A);

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  always_comb begin
    item.last       = in_chan.last;
    item.c.ch       = ch;
    item.c.lc       = up ? (ch + 8'd32) : ch;
    item.c.is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    item.c.is_hex   = 1'b0;
    item.c.hex_val  = 4'd0;
    if ((ch >= 8'h30) && (ch <= 8'h39)) begin
      item.c.is_hex  = 1'b1;
      item.c.hex_val = ch[3:0];
    end else if (((ch >= 8'h61) && (ch <= 8'h66)) || ((ch >= 8'h41) && (ch <= 8'h46))) begin
      // Letters a to f in either case: low three bits run 1..6.
      item.c.is_hex  = 1'b1;
      item.c.hex_val = 4'd9 + {1'b0, ch[2:0]};
    end
  end

endmodule

`default_nettype wire

[sv/ccp_queue.sv]
// Two-entry queue between the front end and the parsing back end.
// Depends on ccp_pkg.
`default_nettype none

module ccp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccp_pkg::ccp_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output ccp_pkg::ccp_item_t rd_item
);

  ccp_pkg::ccp_item_t mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign rd_item = mem_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wr_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop) || !full) else $error("push into full queue");

endmodule

`default_nettype wire

[sv/ccp_back.sv]
// Back end: runs the parse state per character and registers the result.
// Depends on ccp_pkg and ccp_out_if.
`default_nettype none

module ccp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ccp_pkg::ccp_item_t q_item,
  output logic               pop,
  ccp_out_if.source          out_chan
);

  typedef enum logic [2:0] {
    PH_SKIP, PH_PREFIX, PH_NAME, PH_HEX, PH_PAREN, PH_COMPS, PH_RGBEND, PH_END
  } phase_t;

  typedef struct packed {
    phase_t          phase;
    logic [3:0]      char_pos;
    logic [2:0]      hex_count;
    logic            hex_done;
    logic [5:0][3:0] nib;
    logic [26:0]     name_alive;
    logic [2:0][7:0] comp;
    logic [1:0]      comp_index;
    logic [7:0]      cur_value;
    logic            digit_seen;
    logic            skip_to_sep;
  } st_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } res_t;

  localparam ccp_pkg::ccp_char_t ZERO_CH = '0;

  function automatic st_t st_reset();
    st_t s;
    s            = '0;
    s.phase      = PH_SKIP;
    s.name_alive = '1;
    return s;
  endfunction

  // Compare one character against every name at the current position.
  function automatic st_t name_update(st_t s_in, ccp_pkg::ccp_char_t c);
    st_t         s;
    logic [26:0] keep;
    int          base;
    s    = s_in;
    keep = '0;
    for (int i = 0; i < ccp_pkg::NAME_COUNT; i++) begin
      if (c.ch == ccp_pkg::CH_NUL) begin
        keep[i] = (ccp_pkg::NAME_LEN[i] == s.char_pos);
      end else if (s.char_pos < ccp_pkg::NAME_LEN[i]) begin
        base    = (int'(ccp_pkg::NAME_LEN[i]) - 1 - int'(s.char_pos)) * 8;
        keep[i] = (ccp_pkg::NAME_STR[i][base +: 8] == c.lc);
      end
    end
    s.name_alive = s.name_alive & keep;
    if (c.ch == ccp_pkg::CH_NUL) begin
      s.phase = PH_END;
    end else if (s.char_pos != 4'd15) begin
      s.char_pos = s.char_pos + 4'd1;
    end
    return s;
  endfunction

  // A separator, a closing parenthesis or the end closes a component or skipped text; anything else starts skipping.
  function automatic st_t end_item(st_t s_in, ccp_pkg::ccp_char_t c);
    st_t s;
    s = s_in;
    if (c.ch == ccp_pkg::CH_COMMA) begin
      if (s.comp_index == 2'd3) begin
        s.phase = PH_RGBEND;
      end
      s.digit_seen  = 1'b0;
      s.skip_to_sep = 1'b0;
    end else if ((c.ch == ccp_pkg::CH_RPAREN) || (c.ch == ccp_pkg::CH_NUL)) begin
      s.phase = PH_RGBEND;
    end else begin
      s.skip_to_sep = 1'b1;
    end
    return s;
  endfunction

  function automatic st_t feed(st_t s_in, ccp_pkg::ccp_char_t c);
    st_t        s;
    logic [7:0] want;
    s    = s_in;
    want = (s.char_pos == 4'd1) ? ccp_pkg::CH_LOW_G : ccp_pkg::CH_LOW_B;
    unique case (s.phase)
      PH_SKIP: begin
        if (c.ch == ccp_pkg::CH_HASH) begin
          s.phase = PH_HEX;
        end else if (c.ch != ccp_pkg::CH_SPACE) begin
          s.phase = (c.lc == ccp_pkg::CH_LOW_R) ? PH_PREFIX : PH_NAME;
          s       = name_update(s, c);
        end
      end
      PH_PREFIX: begin
        if ((c.ch != ccp_pkg::CH_NUL) && (c.lc == want)) begin
          s = name_update(s, c);
          if (s.char_pos >= 4'd3) begin
            s.phase = PH_PAREN;
          end
        end else begin
          s.phase = PH_NAME;
          s       = name_update(s, c);
        end
      end
      PH_NAME: begin
        s = name_update(s, c);
      end
      PH_HEX: begin
        if (!s.hex_done) begin
          if (!c.is_hex) begin
            s.hex_done = 1'b1;
          end else if (s.hex_count < 3'd6) begin
            s.nib[s.hex_count] = c.hex_val;
            s.hex_count        = s.hex_count + 3'd1;
          end
        end
      end
      PH_PAREN: begin
        if (c.ch == ccp_pkg::CH_LPAREN) begin
          s.phase = PH_COMPS;
        end else if (c.ch == ccp_pkg::CH_NUL) begin
          s.name_alive = '0;
          s.phase      = PH_END;
        end
      end
      PH_COMPS: begin
        if (s.skip_to_sep) begin
          if ((c.ch == ccp_pkg::CH_COMMA) || (c.ch == ccp_pkg::CH_RPAREN) ||
              (c.ch == ccp_pkg::CH_NUL)) begin
            s.skip_to_sep = 1'b0;
            s             = end_item(s, c);
          end
        end else if (s.digit_seen) begin
          if (c.is_digit) begin
            s.cur_value = {s.cur_value[4:0], 3'b000} + {s.cur_value[6:0], 1'b0}
                          + {4'd0, c.ch[3:0]};
          end else begin
            if (s.comp_index != 2'd3) begin
              s.comp[s.comp_index] = s.cur_value;
              s.comp_index         = s.comp_index + 2'd1;
            end
            s.digit_seen = 1'b0;
            s            = end_item(s, c);
          end
        end else if (c.is_digit) begin
          s.cur_value  = {4'd0, c.ch[3:0]};
          s.digit_seen = 1'b1;
        end else if ((c.ch != ccp_pkg::CH_SPACE) && (c.ch != ccp_pkg::CH_COMMA)) begin
          s = end_item(s, c);
        end
      end
      PH_RGBEND: begin
      end
      PH_END: begin
      end
    endcase
    return s;
  endfunction

  function automatic res_t finish(st_t s);
    res_t r;
    r = '0;
    unique case (s.phase)
      PH_HEX: begin
        if (s.hex_count >= 3'd6) begin
          r = {1'b1, s.nib[0], s.nib[1], s.nib[2], s.nib[3], s.nib[4], s.nib[5]};
        end else if (s.hex_count >= 3'd3) begin
          // A digit times 17 repeats the nibble.
          r = {1'b1, s.nib[0], s.nib[0], s.nib[1], s.nib[1], s.nib[2], s.nib[2]};
        end
      end
      PH_RGBEND: begin
        r = {1'b1, s.comp[0], s.comp[1], s.comp[2]};
      end
      PH_END: begin
        // Lowest surviving name wins.
        for (int i = ccp_pkg::NAME_COUNT - 1; i >= 0; i--) begin
          if (s.name_alive[i]) begin
            r = (i == ccp_pkg::IDX_TRANSPARENT) ? res_t'('0)
                                                : {1'b1, ccp_pkg::NAME_RGB[i]};
          end
        end
      end
      PH_SKIP, PH_PREFIX, PH_NAME, PH_PAREN, PH_COMPS: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  st_t  st_r;
  st_t  st_step;
  res_t res_r;
  logic out_valid_r;

  // Only a last character needs the result register; others keep flowing past a held result.
  assign pop     = q_valid && (!out_valid_r || out_chan.ready || !q_item.last);
  assign st_step = feed(st_r, q_item.c);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = res_r.valid_res;
  assign out_chan.red       = res_r.red;
  assign out_chan.green     = res_r.green;
  assign out_chan.blue      = res_r.blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= st_reset();
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && !(pop && q_item.last)) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (q_item.last) begin
          st_r        <= st_reset();
          res_r       <= finish(feed(st_step, ZERO_CH));
          out_valid_r <= 1'b1;
        end else begin
          st_r <= st_step;
        end
      end
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last) |=> out_valid_r) else $error("no result after last character");
  a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last) |=> (st_r.phase == PH_SKIP) && (st_r.char_pos == 4'd0))
    else $error("parse state not restarted after a result");
  a_invalid_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.valid_res) |-> (res_r.red == 8'd0) && (res_r.green == 8'd0) &&
    (res_r.blue == 8'd0)) else $error("invalid result with non-zero channels");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(pop && q_item.last))
    else $error("result overwritten while held");

endmodule

`default_nettype wire

[sv/css_color_string_parser.sv]
// Top level of the CSS colour string parser: front end, queue and back end.
// Depends on ccp_pkg, ccp_if (ccp_in_if, ccp_out_if), ccp_front, ccp_queue and ccp_back.
`default_nettype none

// The parser takes a colour value one character per transfer on in_chan and,
// after the character marked last, delivers one result transfer on out_chan:
// a valid flag and 8-bit red, green and blue, all zero when the string is not
// a colour. Leading spaces are skipped; '#' starts a hex colour (six digits
// give full channels, three to five give each of the first three digits
// times 17), "rgb(" in any case starts up to three decimal components kept
// modulo 256, and anything else must be one of 27 colour names, ignoring
// case. A zero byte ends the string early. One character is taken every
// clock cycle while the queue is not full; the back end updates the parse
// state and matches each character against all names as it pops it.
// A character is written into the queue on its transfer and popped by the
// back end, and the result of a string is loaded into the result register
// when its last character is popped. A two-entry queue separates the front
// end from the back end and a result register separates the back end from
// out_chan, so input keeps flowing while a result waits to be taken, until
// the next last character reaches the back end.
module css_color_string_parser (
  input  wire        clk,
  input  wire        rst_n,
  ccp_in_if.sink     in_chan,
  ccp_out_if.source  out_chan
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  ccp_pkg::ccp_item_t wr_item;
  ccp_pkg::ccp_item_t rd_item;

  // Classification of each incoming character.
  ccp_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .item    (wr_item)
  );

  // Decouples acceptance from parsing so that each side may stall on its own.
  ccp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_item (rd_item)
  );

  // Parse state, name matching and the result register.
  ccp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
